// ----- rtl/lvt_pkg.sv -----
package lvt_pkg;

  // One table row: four 32-bit words, word j at index j.
  typedef logic [3:0][31:0] vec_t;

  localparam logic [31:0] INIT_MULT = 32'd1812433253;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MASK0 = 3'd0;
  localparam logic [2:0] CFG_MASK1 = 3'd1;
  localparam logic [2:0] CFG_MASK2 = 3'd2;
  localparam logic [2:0] CFG_MASK3 = 3'd3;
  localparam logic [2:0] CFG_LSH   = 3'd4;
  localparam logic [2:0] CFG_RSH   = 3'd5;
  localparam logic [2:0] CFG_LAG   = 3'd6;

  // Register reset values.
  localparam logic [31:0] RST_MASK0 = 32'hf7f0bfff;
  localparam logic [31:0] RST_MASK1 = 32'hffad7fdd;
  localparam logic [31:0] RST_MASK2 = 32'hefef7f33;
  localparam logic [31:0] RST_MASK3 = 32'h2d7ce57f;
  localparam logic [4:0]  RST_LSH   = 5'd1;
  localparam logic [4:0]  RST_RSH   = 5'd7;
  localparam logic [7:0]  RST_LAG   = 8'd124;

endpackage

// ----- rtl/lvt_table.sv -----
module lvt_table #(
  parameter int DEPTH = 156,
  parameter int IW    = 8
) (
  input  logic           clk,
  input  logic           we,
  input  logic [IW-1:0]  waddr,
  input  lvt_pkg::vec_t  wdata,
  input  logic           re,
  input  logic [IW-1:0]  raddr_a,
  input  logic [IW-1:0]  raddr_b,
  output lvt_pkg::vec_t  rdata_a,
  output lvt_pkg::vec_t  rdata_b
);
  import lvt_pkg::*;

  vec_t mem [DEPTH];
  vec_t rd_a_r;
  vec_t rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// ----- rtl/lvt_mix.sv -----
module lvt_mix (
  input  lvt_pkg::vec_t  vec_a,
  input  lvt_pkg::vec_t  vec_b,
  input  lvt_pkg::vec_t  vec_c,
  input  lvt_pkg::vec_t  mask,
  input  logic [4:0]     lsh,
  input  logic [4:0]     rsh,
  output lvt_pkg::vec_t  vec_r
);
  import lvt_pkg::*;

  for (genvar j = 0; j < 4; j++) begin : g_word
    // The rotated operand takes word (j+1) mod 4 of the lagged vector.
    assign vec_r[j] = vec_a[j] ^ vec_b[(j + 1) % 4] ^ (vec_b[j] << lsh)
                    ^ (vec_c[j] & mask[j]) ^ (vec_c[j] >> rsh);
  end

endmodule

// ----- rtl/lvt_seed_mul.sv -----
module lvt_seed_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] prev_word,
  output logic [31:0] prod
);
  import lvt_pkg::*;

  logic [31:0] folded;
  logic [31:0] prod_nxt;
  logic [31:0] prod_r;

  assign folded   = prev_word ^ (prev_word >> 30);
  // Only the low 32 bits of the product are kept.
  assign prod_nxt = INIT_MULT * folded;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ----- rtl/lagged_vector_twister_prng.sv -----
// Lagged vector twister random generator. The table holds VECTOR_COUNT rows of
// four 32-bit words in a memory with two read ports and one write port. After
// reset a clearing pass writes zeros to every row of the table, and no request
// is taken meanwhile. A seed request (in_tuser = 0) runs the seed recurrence
// through one multiplier, a multiply state and an add state for each word,
// and gives no result. A next request (in_tuser = 1) reads one table row in
// S_OUT_RD; S_OUT_DO then loads the word into the output register, waiting
// while that register still holds an untaken word, and the block returns to
// idle. When the table is used up, the request first reduces the lag modulo
// VECTOR_COUNT by repeated subtraction, fetches the last row, and then
// regenerates the table in place with the shared mixing unit, a read and then
// a write for each row.
// The output register lets the next request be accepted while a word waits.
module lagged_vector_twister_prng #(
  parameter int VECTOR_COUNT = 156
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic        in_tuser,   // [0] req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] rand_word
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import lvt_pkg::*;

  localparam int IW  = $clog2(VECTOR_COUNT);
  localparam int RIW = $clog2(4 * VECTOR_COUNT + 1);
  localparam int LW  = (IW + 1 > 8) ? IW + 1 : 8;

  localparam logic [IW-1:0]  LAST_ROW   = IW'(VECTOR_COUNT - 1);
  localparam logic [RIW-1:0] TABLE_END  = RIW'(4 * VECTOR_COUNT);
  localparam logic [RIW-1:0] LAST_WORD  = RIW'(4 * VECTOR_COUNT - 1);
  localparam logic [LW-1:0]  VC_LW      = LW'(VECTOR_COUNT);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SEED_MUL,
    S_SEED_ADD,
    S_LAG,
    S_RG_CRD,
    S_RG_CLD,
    S_RG_RD,
    S_RG_WR,
    S_OUT_RD,
    S_OUT_DO
  } state_t;

  state_t         state_r;
  logic [RIW-1:0] idx_r;
  logic [RIW-1:0] seed_i_r;
  logic [IW-1:0]  k_r;
  logic [IW-1:0]  bk_r;
  logic [LW-1:0]  lag_w_r;
  logic [31:0]    p_r;
  vec_t           row_buf_r;
  vec_t           c_r;
  logic           out_tvalid_r;
  logic [31:0]    out_tdata_r;

  vec_t           mask_r;
  logic [4:0]     lsh_r;
  logic [4:0]     rsh_r;
  logic [7:0]     lag_r;

  logic           mem_we;
  logic [IW-1:0]  mem_wa;
  vec_t           mem_wd;
  logic           mem_re;
  logic [IW-1:0]  mem_ra;
  vec_t           mem_rd_a;
  vec_t           mem_rd_b;

  logic [31:0]    prod;
  logic [31:0]    seed_word;
  vec_t           seed_row;
  vec_t           mix_r;

  lvt_table #(
    .DEPTH (VECTOR_COUNT),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_wa),
    .wdata   (mem_wd),
    .re      (mem_re),
    .raddr_a (mem_ra),
    .raddr_b (bk_r),
    .rdata_a (mem_rd_a),
    .rdata_b (mem_rd_b)
  );

  lvt_mix u_mix (
    .vec_a (mem_rd_a),
    .vec_b (mem_rd_b),
    .vec_c (c_r),
    .mask  (mask_r),
    .lsh   (lsh_r),
    .rsh   (rsh_r),
    .vec_r (mix_r)
  );

  lvt_seed_mul u_seed_mul (
    .clk       (clk),
    .en        (state_r == S_SEED_MUL),
    .prev_word (p_r),
    .prod      (prod)
  );

  assign seed_word = prod + 32'(seed_i_r);

  always_comb begin
    seed_row = row_buf_r;
    seed_row[seed_i_r[1:0]] = seed_word;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = k_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = k_r;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_SEED_ADD: begin
        if (seed_i_r[1:0] == 2'd3) begin
          mem_we = 1'b1;
          mem_wa = seed_i_r[IW+1:2];
          mem_wd = seed_row;
        end
      end
      S_RG_CRD: begin
        mem_re = 1'b1;
        mem_ra = LAST_ROW;
      end
      S_RG_RD: begin
        mem_re = 1'b1;
      end
      S_RG_WR: begin
        mem_we = 1'b1;
        mem_wd = mix_r;
      end
      S_OUT_RD: begin
        mem_re = 1'b1;
        mem_ra = idx_r[IW+1:2];
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= RST_MASK0;
      mask_r[1] <= RST_MASK1;
      mask_r[2] <= RST_MASK2;
      mask_r[3] <= RST_MASK3;
      lsh_r     <= RST_LSH;
      rsh_r     <= RST_RSH;
      lag_r     <= RST_LAG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASK0: mask_r[0] <= cfg_wdata;
        CFG_MASK1: mask_r[1] <= cfg_wdata;
        CFG_MASK2: mask_r[2] <= cfg_wdata;
        CFG_MASK3: mask_r[3] <= cfg_wdata;
        CFG_LSH:   lsh_r     <= cfg_wdata[4:0];
        CFG_RSH:   rsh_r     <= cfg_wdata[4:0];
        CFG_LAG:   lag_r     <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      idx_r        <= TABLE_END;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // In S_OUT_DO the state machine itself decides the valid flag.
      if (out_tvalid_r && out_tready && (state_r != S_OUT_DO)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (k_r == LAST_ROW) begin
            k_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            if (!in_tuser) begin
              p_r          <= in_tdata;
              row_buf_r[0] <= in_tdata;
              seed_i_r     <= RIW'(1);
              state_r      <= S_SEED_MUL;
            end else if (idx_r == TABLE_END) begin
              lag_w_r <= LW'(lag_r);
              state_r <= S_LAG;
            end else begin
              state_r <= S_OUT_RD;
            end
          end
        end
        S_SEED_MUL: begin
          state_r <= S_SEED_ADD;
        end
        S_SEED_ADD: begin
          p_r                      <= seed_word;
          row_buf_r[seed_i_r[1:0]] <= seed_word;
          if (seed_i_r == LAST_WORD) begin
            idx_r   <= TABLE_END;
            state_r <= S_IDLE;
          end else begin
            seed_i_r <= seed_i_r + 1'b1;
            state_r  <= S_SEED_MUL;
          end
        end
        S_LAG: begin
          // Reduce the lag modulo the row count by repeated subtraction.
          if (lag_w_r >= VC_LW) begin
            lag_w_r <= lag_w_r - VC_LW;
          end else begin
            bk_r    <= lag_w_r[IW-1:0];
            state_r <= S_RG_CRD;
          end
        end
        S_RG_CRD: begin
          state_r <= S_RG_CLD;
        end
        S_RG_CLD: begin
          c_r     <= mem_rd_a;
          k_r     <= '0;
          state_r <= S_RG_RD;
        end
        S_RG_RD: begin
          state_r <= S_RG_WR;
        end
        S_RG_WR: begin
          // The row is written before the next read, so a lagged row that
          // was already replaced is read in its new form.
          c_r <= mix_r;
          if (bk_r == LAST_ROW) begin
            bk_r <= '0;
          end else begin
            bk_r <= bk_r + 1'b1;
          end
          if (k_r == LAST_ROW) begin
            k_r     <= '0;
            idx_r   <= '0;
            state_r <= S_OUT_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RG_RD;
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_DO;
        end
        S_OUT_DO: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= mem_rd_a[idx_r[1:0]];
            out_tvalid_r <= 1'b1;
            idx_r        <= idx_r + 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- verif/lagged_vector_twister_prng_tb.sv -----
module lagged_vector_twister_prng_tb;
  import lvt_pkg::*;

  localparam int VC            = 156;
  localparam int TABLE_WORDS   = 4 * VC;
  // A seed request keeps the block busy while it refills every row of the table.
  localparam int SETTLE_CYCLES = 8 * VC + 256;
  localparam int STALL_LIMIT   = 40000;
  localparam int PHASE_ITEMS   = 110;
  localparam int LONG_RUN      = 640;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_NEXT = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [31:0] data;
    bit          known;
    logic [31:0] want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] seed
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] rand_word
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Generator state as the block should hold it.
  vec_t        gen_rows [VC];
  vec_t        gen_mask;
  logic [4:0]  gen_lsh;
  logic [4:0]  gen_rsh;
  logic [7:0]  gen_lag;
  int unsigned gen_ptr;

  logic [31:0] rand_word_q [$];
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles   = 0;
  int          quiet_cycles  = 0;
  bit          offering      = 1'b0;

  // Requests right after reset see an all-zero table, which twists to zeros.
  dir_row_t dir_tab [17] = '{
    '{REQ_NEXT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{REQ_NEXT, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_SEED, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000},
    '{REQ_SEED, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{REQ_SEED, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_SEED, 32'h0000_0001, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_SEED, 32'h1234_5678, 1'b0, 32'h0000_0000},
    '{REQ_SEED, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'h0F0F_0F0F, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'hF0F0_F0F0, 1'b0, 32'h0000_0000},
    '{REQ_NEXT, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  lagged_vector_twister_prng #(
    .VECTOR_COUNT(VC)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_generator();
    foreach (gen_rows[k]) gen_rows[k] = '0;
    gen_mask = {RST_MASK3, RST_MASK2, RST_MASK1, RST_MASK0};
    gen_lsh  = RST_LSH;
    gen_rsh  = RST_RSH;
    gen_lag  = RST_LAG;
    gen_ptr  = TABLE_WORDS;
  endfunction

  function automatic void seed_rows(logic [31:0] s);
    logic [31:0] p;
    logic [31:0] w;
    gen_rows[0][0] = s;
    p = s;
    for (int i = 1; i < TABLE_WORDS; i++) begin
      w = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
      gen_rows[i / 4][i % 4] = w;
      p = w;
    end
    gen_ptr = TABLE_WORDS;
  endfunction

  // In-place twist: the lagged row may already hold its new value.
  function automatic void twist_rows();
    vec_t        a;
    vec_t        b;
    vec_t        c;
    vec_t        r;
    int unsigned lag;
    lag = gen_lag % VC;
    c = gen_rows[VC - 1];
    for (int k = 0; k < VC; k++) begin
      a = gen_rows[k];
      b = gen_rows[(k + lag) % VC];
      for (int j = 0; j < 4; j++) begin
        r[j] = a[j] ^ b[(j + 1) % 4] ^ (b[j] << gen_lsh) ^ (c[j] & gen_mask[j])
               ^ (c[j] >> gen_rsh);
      end
      gen_rows[k] = r;
      c = r;
    end
  endfunction

  function automatic bit advance_generator(req_kind_t kind, logic [31:0] data,
                                           output logic [31:0] word);
    word = '0;
    if (kind == REQ_SEED) begin
      seed_rows(data);
      return 1'b0;
    end
    if (gen_ptr >= TABLE_WORDS) begin
      twist_rows();
      gen_ptr = 0;
    end
    word = gen_rows[gen_ptr / 4][gen_ptr % 4];
    gen_ptr++;
    return 1'b1;
  endfunction

  task automatic send_item(req_kind_t kind, logic [31:0] data, bit known,
                           logic [31:0] want);
    logic [31:0] word;
    int          gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (advance_generator(kind, data, word)) rand_word_q.push_back(known ? want : word);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (rand_word_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MASK0: gen_mask[0] = val;
      CFG_MASK1: gen_mask[1] = val;
      CFG_MASK2: gen_mask[2] = val;
      CFG_MASK3: gen_mask[3] = val;
      CFG_LSH:   gen_lsh = val[4:0];
      CFG_RSH:   gen_rsh = val[4:0];
      CFG_LAG:   gen_lag = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_phase(int p);
    logic [31:0] vals [7];
    wait_all_results();
    // A seed request leaves no result behind, so let any fill run out.
    repeat (SETTLE_CYCLES) @(posedge clk);
    case (p)
      0: vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd0, 32'd0};
      1: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'd31, 32'd31, 32'd155};
      2: vals = '{$urandom, $urandom, $urandom, $urandom,
                  $urandom_range(31), $urandom_range(31), 32'd255};
      3: vals = '{RST_MASK0, RST_MASK1, RST_MASK2, RST_MASK3,
                  32'(RST_LSH), 32'(RST_RSH), 32'd156};
      default: foreach (vals[i]) vals[i] = $urandom;
    endcase
    write_reg(CFG_MASK0, vals[0]);
    write_reg(CFG_MASK1, vals[1]);
    write_reg(CFG_MASK2, vals[2]);
    write_reg(CFG_MASK3, vals[3]);
    write_reg(CFG_LSH, vals[4]);
    write_reg(CFG_RSH, vals[5]);
    write_reg(CFG_LAG, vals[6]);
    if (p == 0) write_reg(CFG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  // A long run reads past the end of the table into a second twist. Partway
  // through, the receiver holds off so that the block backs up into its input.
  task automatic run_burst(int len, bit reseed);
    if (reseed) send_item(REQ_SEED, $urandom, 1'b0, '0);
    for (int i = 0; i < len; i++) begin
      if (i == 50 && len > 100) hold_cycles = 500;
      if (len <= 100 && $urandom_range(24) == 0) send_item(REQ_SEED, $urandom, 1'b0, '0);
      else send_item(REQ_NEXT, $urandom, 1'b0, '0);
    end
    if ($urandom_range(4) == 0) wait_all_results();
  endtask

  always @(posedge clk) begin : check_results
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rand_word_q.size() == 0) begin
        $display("%0t: rand_word %08h with no request outstanding", $time, out_tdata);
        mismatches++;
      end else begin
        want = rand_word_q.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: rand_word mismatch, expected %08h, got %08h",
                   $time, want, out_tdata);
          mismatches++;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("lagged_vector_twister_prng verification failed");
      $finish;
    end
  end

  initial begin
    int start;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    reset_generator();
    send_idle_pct = 22;
    recv_idle_pct = 57;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].kind, dir_tab[i].data, dir_tab[i].known,
                                   dir_tab[i].want);

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 22 : (p < 4) ? 57 : 0;
      recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 22 : 0;
      program_phase(p);
      start = items_sent;
      if (p == 1 || p == 4) run_burst(LONG_RUN, 1'b1);
      while (items_sent - start < PHASE_ITEMS) begin
        run_burst($urandom_range(1, 40), $urandom_range(5) != 0);
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("lagged_vector_twister_prng verification clean");
    end else begin
      $display("lagged_vector_twister_prng verification failed");
    end
    $finish;
  end

endmodule
